>>> rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types, field widths, codes and parameter defaults of the
// counting semaphore engine.
// ----------------------------------------------------------------------------
package cse_pkg;

  // Fixed widths of the item fields.
  localparam int ACTION_W = 2;
  localparam int ID_W     = 4;
  localparam int PIDF_W   = 4;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 3;

  // Defaults of the top level parameters.
  localparam int DEF_NUM_SEMS    = 16;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_PID_BITS    = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Action codes of an input item.
  localparam logic [ACTION_W-1:0] ACT_GET  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WAIT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POST = 2'd2;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RAISED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WOKEN     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

  // Operation class decided by the front end.
  typedef enum logic [1:0] {
    OP_GET,
    OP_WAIT,
    OP_POST,
    OP_REJECT
  } op_kind_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_WAKE,
    B_DONE
  } back_state_t;

endpackage

>>> rtl/cse_if.sv
// ----------------------------------------------------------------------------
// cse_in_if / cse_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface cse_in_if;
  logic                           valid;
  logic                           ready;
  logic [cse_pkg::ACTION_W-1:0]   action;
  logic [cse_pkg::ID_W-1:0]       sem_id;
  logic [cse_pkg::PIDF_W-1:0]     caller_pid;
  logic [cse_pkg::COUNT_W-1:0]    init_count;

  modport source (output valid, action, sem_id, caller_pid, init_count, input ready);
  modport sink   (input valid, action, sem_id, caller_pid, init_count, output ready);
endinterface

interface cse_out_if;
  logic                           valid;
  logic                           ready;
  logic [cse_pkg::STATUS_W-1:0]   status;
  logic [cse_pkg::ID_W-1:0]       new_sem_id;
  logic [cse_pkg::PIDF_W-1:0]     woken_pid;

  modport source (output valid, status, new_sem_id, woken_pid, input ready);
  modport sink   (input valid, status, new_sem_id, woken_pid, output ready);
endinterface

>>> rtl/counting_semaphore_engine_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_engine_core
// Hardware counting semaphores with FIFO wait queues and a pool of IDs.
// ----------------------------------------------------------------------------
// Usage: request items arrive on in_item (action, sem_id, caller_pid,
// init_count) and each one gives exactly one result item on out_item
// (status, new_sem_id, woken_pid). Both channels use valid/ready.
// A two-entry queue decouples the request side from the execution side,
// so requests are taken while the sequencer works or a result waits.
// The sequencer handles one item at a time: a semaphore RAM read, an
// update step and a result step, with an extra wait-RAM read for a post
// that wakes a waiter, whose ID it fetches; it takes the next item only
// once the result has moved into the output register.
// If the receiver stalls, the result holds in the output register, the
// sequencer holds the next result, and the request queue then fills and
// drops in_item.ready.
// Reset clears control state: all semaphores read as count 0 with an
// empty queue and the ID pool holds every ID. No clearing pass is needed.
// ----------------------------------------------------------------------------
module counting_semaphore_engine_core #(
  parameter int NUM_SEMS    = cse_pkg::DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = cse_pkg::DEF_QUEUE_DEPTH,
  parameter int PID_BITS    = cse_pkg::DEF_PID_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  cse_in_if.sink     in_item,
  cse_out_if.source  out_item
);
  import cse_pkg::*;

  localparam int SEM_W = $clog2(NUM_SEMS);

  logic                op_valid, op_ready;
  op_kind_t            op_kind;
  logic [SEM_W-1:0]    op_sem;
  logic [PID_BITS-1:0] op_pid;
  logic [COUNT_W-1:0]  op_init;

  cse_front #(.NUM_SEMS(NUM_SEMS), .PID_BITS(PID_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op_kind  (op_kind),
    .op_sem   (op_sem),
    .op_pid   (op_pid),
    .op_init  (op_init)
  );

  cse_back #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op_kind  (op_kind),
    .op_sem   (op_sem),
    .op_pid   (op_pid),
    .op_init  (op_init),
    .out_item (out_item)
  );

  // Only a wake reports a process ID.
  a_pid_only_on_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.status != ST_WOKEN |-> out_item.woken_pid == '0)
    else $error("woken_pid set on a result that is not a wake");

  // Only an allocation reports a semaphore ID.
  a_sem_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && out_item.status != ST_ALLOCATED |-> out_item.new_sem_id == '0)
    else $error("new_sem_id set on a result that is not an allocation");

  // No result is shown in the cycle after reset.
  a_no_result_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_item.valid)
    else $error("result valid right after reset");

  // The sequencer takes a request only when idle, so after taking a get it
  // cannot take another one in the next cycle.
  a_reject_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    op_valid && op_ready && op_kind == OP_GET |=> !(op_valid && op_ready))
    else $error("sequencer took two requests in consecutive cycles");
endmodule

>>> rtl/cse_ram.sv
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One address per cycle: a write, and a read that lands next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Accepts request items, classifies them and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module cse_front #(
  parameter int NUM_SEMS = cse_pkg::DEF_NUM_SEMS,
  parameter int PID_BITS = cse_pkg::DEF_PID_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cse_in_if.sink                          in_item,
  output logic                            op_valid,
  input  logic                            op_ready,
  output cse_pkg::op_kind_t               op_kind,
  output logic [$clog2(NUM_SEMS)-1:0]     op_sem,
  output logic [PID_BITS-1:0]             op_pid,
  output logic [cse_pkg::COUNT_W-1:0]     op_init
);
  import cse_pkg::*;

  localparam int SEM_W = $clog2(NUM_SEMS);

  op_kind_t           kind_q [2];
  logic [SEM_W-1:0]   sem_q  [2];
  logic [PID_BITS-1:0] pid_q [2];
  logic [COUNT_W-1:0] init_q [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         count_r;
  op_kind_t           kind_c;
  logic               push, pop;

  // Classify the item: out-of-range IDs on a wait or post and unknown actions are rejected.
  always_comb begin
    if (in_item.action == ACT_GET) begin
      kind_c = OP_GET;
    end else if (in_item.action == ACT_WAIT &&
                 32'(in_item.sem_id) < NUM_SEMS) begin
      kind_c = OP_WAIT;
    end else if (in_item.action == ACT_POST &&
                 32'(in_item.sem_id) < NUM_SEMS) begin
      kind_c = OP_POST;
    end else begin
      kind_c = OP_REJECT;
    end
  end

  assign in_item.ready = (count_r != 2'd2);
  assign push          = in_item.valid && in_item.ready;
  assign pop           = op_valid && op_ready;

  assign op_valid = (count_r != 2'd0);
  assign op_kind  = kind_q[rd_ptr_r];
  assign op_sem   = sem_q[rd_ptr_r];
  assign op_pid   = pid_q[rd_ptr_r];
  assign op_init  = init_q[rd_ptr_r];

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr_r] <= kind_c;
      sem_q[wr_ptr_r]  <= SEM_W'(in_item.sem_id);
      pid_q[wr_ptr_r]  <= PID_BITS'(in_item.caller_pid);
      init_q[wr_ptr_r] <= in_item.init_count;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end
endmodule

>>> rtl/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Carries out one operation at a time: reads the semaphore entry, updates
// count, queue pointers, wait entries and ID pool, and registers the result.
// ----------------------------------------------------------------------------
module cse_back #(
  parameter int NUM_SEMS    = cse_pkg::DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = cse_pkg::DEF_QUEUE_DEPTH,
  parameter int PID_BITS    = cse_pkg::DEF_PID_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            op_valid,
  output logic                            op_ready,
  input  cse_pkg::op_kind_t               op_kind,
  input  logic [$clog2(NUM_SEMS)-1:0]     op_sem,
  input  logic [PID_BITS-1:0]             op_pid,
  input  logic [cse_pkg::COUNT_W-1:0]     op_init,
  cse_out_if.source                       out_item
);
  import cse_pkg::*;

  localparam int SEM_W = $clog2(NUM_SEMS);
  localparam int FS_W  = $clog2(NUM_SEMS + 1);
  localparam int QP_W  = $clog2(QUEUE_DEPTH);
  localparam int QS_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = COUNT_W + QP_W + QS_W;
  localparam int EA_W  = $clog2(NUM_SEMS * QUEUE_DEPTH);

  back_state_t         state_r, state_nxt;
  op_kind_t            kind_r;
  logic [SEM_W-1:0]    sem_r;
  logic [PID_BITS-1:0] pid_r;
  logic [COUNT_W-1:0]  init_r;
  logic [SEM_W-1:0]    free_head_r, free_head_nxt;
  logic [FS_W-1:0]     free_size_r, free_size_nxt;
  logic [NUM_SEMS-1:0] valid_r;
  logic                valid_set;
  logic [SEM_W-1:0]    valid_idx;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_sem_r, res_sem_nxt;
  logic [PIDF_W-1:0]   res_pid_r, res_pid_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_sem_r;
  logic [PIDF_W-1:0]   out_pid_r;
  logic                out_load;

  // Semaphore state RAM: {count, queue head, queue size}.
  logic                sram_we;
  logic [SEM_W-1:0]    sram_addr;
  logic [SW-1:0]       sram_wdata, sram_q;
  // Wait entry RAM, one row of QUEUE_DEPTH entries per semaphore.
  logic                eram_we;
  logic [EA_W-1:0]     eram_addr;
  logic [PID_BITS-1:0] eram_q;

  logic [COUNT_W-1:0]  cur_count;
  logic [QP_W-1:0]     cur_head, head_inc;
  logic [QS_W-1:0]     cur_size;
  logic [QS_W:0]       pos_sum;
  logic [QP_W-1:0]     tail_pos;
  logic [EA_W-1:0]     row_base;

  cse_ram #(.WIDTH(SW), .DEPTH(NUM_SEMS)) u_sem_ram (
    .clk   (clk),
    .we    (sram_we),
    .addr  (sram_addr),
    .wdata (sram_wdata),
    .rdata (sram_q)
  );

  cse_ram #(.WIDTH(PID_BITS), .DEPTH(NUM_SEMS * QUEUE_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (eram_we),
    .addr  (eram_addr),
    .wdata (pid_r),
    .rdata (eram_q)
  );

  // A semaphore never written since reset reads as all zero.
  always_comb begin
    if (valid_r[sem_r]) begin
      {cur_count, cur_head, cur_size} = sram_q;
    end else begin
      {cur_count, cur_head, cur_size} = '0;
    end
  end

  // Queue position arithmetic: tail slot and advanced head, with wrap.
  assign pos_sum  = (QS_W+1)'(cur_head) + (QS_W+1)'(cur_size);
  assign tail_pos = (pos_sum >= (QS_W+1)'(QUEUE_DEPTH)) ?
                    QP_W'(pos_sum - (QS_W+1)'(QUEUE_DEPTH)) : QP_W'(pos_sum);
  assign head_inc = (cur_head == QP_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + QP_W'(1);
  assign row_base = EA_W'(sem_r) * EA_W'(QUEUE_DEPTH);

  assign out_load = !out_valid_r || out_item.ready;
  assign op_ready = (state_r == B_IDLE);

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_nxt      = state_r;
    sram_we        = 1'b0;
    sram_addr      = sem_r;
    sram_wdata     = sram_q;
    eram_we        = 1'b0;
    eram_addr      = row_base + EA_W'(tail_pos);
    valid_set      = 1'b0;
    valid_idx      = sem_r;
    free_head_nxt  = free_head_r;
    free_size_nxt  = free_size_r;
    res_status_nxt = res_status_r;
    res_sem_nxt    = res_sem_r;
    res_pid_nxt    = res_pid_r;
    case (state_r)
      B_IDLE: begin
        sram_addr = op_sem;
        if (op_valid) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        state_nxt      = B_DONE;
        res_sem_nxt    = '0;
        res_pid_nxt    = '0;
        res_status_nxt = ST_NONE;
        case (kind_r)
          OP_GET: begin
            if (free_size_r != '0) begin
              sram_we        = 1'b1;
              sram_addr      = free_head_r;
              sram_wdata     = {init_r, QP_W'(0), QS_W'(0)};
              valid_set      = 1'b1;
              valid_idx      = free_head_r;
              free_head_nxt  = (free_head_r == SEM_W'(NUM_SEMS - 1)) ?
                               '0 : free_head_r + SEM_W'(1);
              free_size_nxt  = free_size_r - FS_W'(1);
              res_status_nxt = ST_ALLOCATED;
              res_sem_nxt    = ID_W'(free_head_r);
            end
          end
          OP_WAIT: begin
            if (cur_count != '0) begin
              sram_we        = 1'b1;
              valid_set      = 1'b1;
              sram_wdata     = {cur_count - COUNT_W'(1), cur_head, cur_size};
              res_status_nxt = ST_GRANTED;
            end else if (cur_size == QS_W'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              sram_we        = 1'b1;
              valid_set      = 1'b1;
              sram_wdata     = {cur_count, cur_head, cur_size + QS_W'(1)};
              eram_we        = 1'b1;
              res_status_nxt = ST_BLOCKED;
            end
          end
          OP_POST: begin
            sram_we   = 1'b1;
            valid_set = 1'b1;
            if (cur_size == '0) begin
              sram_wdata = {(cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1),
                            cur_head, cur_size};
              res_status_nxt = ST_RAISED;
            end else begin
              // Fetch the oldest waiter; its ID arrives next cycle.
              sram_wdata     = {cur_count, head_inc, cur_size - QS_W'(1)};
              eram_addr      = row_base + EA_W'(cur_head);
              res_status_nxt = ST_WOKEN;
              state_nxt      = B_WAKE;
            end
          end
          default: begin
            res_status_nxt = ST_NONE;
          end
        endcase
      end
      B_WAKE: begin
        res_pid_nxt = PIDF_W'(eram_q);
        state_nxt   = B_DONE;
      end
      B_DONE: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      free_head_r <= '0;
      free_size_r <= FS_W'(NUM_SEMS);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      free_size_r <= free_size_nxt;
      if (valid_set) begin
        valid_r[valid_idx] <= 1'b1;
      end
      if (state_r == B_DONE && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operation, result and output payload registers.
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && op_valid) begin
      kind_r <= op_kind;
      sem_r  <= op_sem;
      pid_r  <= op_pid;
      init_r <= op_init;
    end
    res_status_r <= res_status_nxt;
    res_sem_r    <= res_sem_nxt;
    res_pid_r    <= res_pid_nxt;
    if (state_r == B_DONE && out_load) begin
      out_status_r <= res_status_r;
      out_sem_r    <= res_sem_r;
      out_pid_r    <= res_pid_r;
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.status     = out_status_r;
  assign out_item.new_sem_id = out_sem_r;
  assign out_item.woken_pid  = out_pid_r;
endmodule

>>> dv/tb_counting_semaphore_engine_core.sv
// ----------------------------------------------------------------------------
// tb_counting_semaphore_engine_core
// Drives request items with random gaps, predicts every result item from a
// local model of the semaphores, queues and ID pool, and checks each result
// in order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cse_pkg::*;

  localparam int NSEM  = DEF_NUM_SEMS;
  localparam int QDEP  = DEF_QUEUE_DEPTH;
  localparam int PBITS = DEF_PID_BITS;

  // Action code that the block does not define.
  localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     sem_id;
    logic [PIDF_W-1:0]   caller_pid;
    logic [COUNT_W-1:0]  init_count;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     new_sem_id;
    logic [PIDF_W-1:0]   woken_pid;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cse_in_if  req_ch();
  cse_out_if res_ch();

  counting_semaphore_engine_core dut (
    .clk(clk), .rst_n(rst_n), .in_item(req_ch.sink), .out_item(res_ch.source)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [COUNT_W-1:0] p_count [NSEM];
  logic [PBITS-1:0]   p_entry [NSEM][QDEP];
  int                 p_head  [NSEM];
  int                 p_size  [NSEM];
  int                 p_pool  [NSEM];
  int                 p_fhead;
  int                 p_fsize;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   mismatches = 0;

  function automatic res_t predict_result(req_t r);
    res_t o;
    int   id;
    int   s;
    o = '0;
    s = r.sem_id;
    if (r.action == ACT_GET) begin
      if (p_fsize == 0) begin
        o.status = ST_NONE;
      end else begin
        id = p_pool[p_fhead];
        p_fhead = (p_fhead + 1) % NSEM;
        p_fsize--;
        p_head[id] = 0;
        p_size[id] = 0;
        p_count[id] = r.init_count;
        o.status = ST_ALLOCATED;
        o.new_sem_id = ID_W'(id);
      end
    end else if (r.action != ACT_WAIT && r.action != ACT_POST || s >= NSEM) begin
      o.status = ST_NONE;
    end else if (r.action == ACT_WAIT) begin
      if (p_count[s] > 0) begin
        p_count[s]--;
        o.status = ST_GRANTED;
      end else if (p_size[s] >= QDEP) begin
        o.status = ST_FULL;
      end else begin
        p_entry[s][(p_head[s] + p_size[s]) % QDEP] = r.caller_pid[PBITS-1:0];
        p_size[s]++;
        o.status = ST_BLOCKED;
      end
    end else begin
      if (p_size[s] == 0) begin
        if (p_count[s] != COUNT_MAX) p_count[s]++;
        o.status = ST_RAISED;
      end else begin
        o.woken_pid = p_entry[s][p_head[s]];
        p_head[s] = (p_head[s] + 1) % QDEP;
        p_size[s]--;
        o.status = ST_WOKEN;
      end
    end
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Driver: presents queued items, with random gaps between them.
  int drv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // Hold the item until it is taken.
    end else begin
      if (req_ch.valid) begin
        expected_results.push_back(predict_result(req_t'({req_ch.action,
          req_ch.sem_id, req_ch.caller_pid, req_ch.init_count})));
      end
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        {req_ch.action, req_ch.sem_id, req_ch.caller_pid, req_ch.init_count} <= r;
        req_ch.valid <= 1'b1;
        drv_gap <= gap_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  int mon_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        res_t got;
        res_t exp_r;
        got = {res_ch.status, res_ch.new_sem_id, res_ch.woken_pid};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected st=%0d id=%0d pid=%0d, got st=%0d id=%0d pid=%0d",
                       exp_r.status, exp_r.new_sem_id, exp_r.woken_pid,
                       got.status, got.new_sem_id, got.woken_pid);
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        mon_gap <= gap_len();
      end
    end
  end

  function automatic req_t mk(logic [1:0] a, int s, int p, int c);
    req_t r;
    r.action = a;
    r.sem_id = ID_W'(s);
    r.caller_pid = PIDF_W'(p);
    r.init_count = COUNT_W'(c);
    return r;
  endfunction

  // Stimulus and end of run.
  initial begin
    int k;
    int live;
    req_ch.valid = 1'b0;
    req_ch.action = '0; req_ch.sem_id = '0; req_ch.caller_pid = '0;
    req_ch.init_count = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < NSEM; i++) begin
      p_count[i] = '0; p_head[i] = 0; p_size[i] = 0; p_pool[i] = i;
      for (int j = 0; j < QDEP; j++) p_entry[i][j] = '0;
    end
    p_fhead = 0;
    p_fsize = NSEM;

    // Directed: unallocated semaphores, undefined action, max and zero counts.
    pending_reqs.push_back(mk(ACT_POST, 15, 0, 0));
    pending_reqs.push_back(mk(ACT_WAIT, 15, 0, 0));
    pending_reqs.push_back(mk(ACT_WAIT, 3, 15, 65535));
    pending_reqs.push_back(mk(ACT_POST, 3, 0, 0));
    pending_reqs.push_back(mk(ACT_UNDEF, 5, 9, 65535));
    pending_reqs.push_back(mk(ACT_GET, 0, 0, 65535));
    pending_reqs.push_back(mk(ACT_POST, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_WAIT, 0, 0, 0));
    pending_reqs.push_back(mk(ACT_GET, 0, 0, 0));
    // Fill the wait queue of semaphore 1, then overflow it.
    for (int i = 0; i < QDEP + 1; i++) pending_reqs.push_back(mk(ACT_WAIT, 1, i, 0));
    pending_reqs.push_back(mk(ACT_POST, 1, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Random: mostly well-formed traffic, gets spread so the pool drains late.
    for (k = 0; k < 1300; k++) begin
      req_t r;
      int sel;
      sel = $urandom_range(0, 99);
      live = $urandom_range(0, 99) < 70 ? $urandom_range(0, 3) : $urandom_range(0, 15);
      r.sem_id = ID_W'(live);
      r.caller_pid = PIDF_W'($urandom);
      r.init_count = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom) :
                     COUNT_W'($urandom_range(0, 3));
      if ($urandom_range(0, 30) == 0) r.init_count = 16'hFFFF;
      if (sel < 2) r.action = ACT_GET;
      else if (sel < 50) r.action = ACT_WAIT;
      else if (sel < 96) r.action = ACT_POST;
      else r.action = ACT_UNDEF;
      pending_reqs.push_back(r);
    end
    // Exhaust the pool.
    for (int i = 0; i < NSEM + 2; i++) pending_reqs.push_back(mk(ACT_GET, 0, 0, 1));

    while (pending_reqs.size() > 0 || req_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("counting_semaphore_engine_core: match");
    end else begin
      $display("counting_semaphore_engine_core: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("counting_semaphore_engine_core: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/cse_pkg.sv
rtl/cse_if.sv
rtl/cse_ram.sv
rtl/cse_front.sv
rtl/cse_back.sv
rtl/counting_semaphore_engine_core.sv
dv/tb_counting_semaphore_engine_core.sv
